@@ rtl/fpra_pkg.sv @@
// Package for the vector register slot allocator.
// Holds the request action codes, configuration register indexes, reset values and scratch limits.
// No dependencies.
`timescale 1ns / 1ps

package fpra_pkg;

  // Request actions
  typedef enum logic [3:0] {
    ACT_GET_SINGLE     = 4'd0,
    ACT_GET_PAIR       = 4'd1,
    ACT_FREE_SINGLE    = 4'd2,
    ACT_FREE_PAIR      = 4'd3,
    ACT_CLEAR_ALL      = 4'd4,
    ACT_SCRATCH_SINGLE = 4'd5,
    ACT_SCRATCH_DOUBLE = 4'd6,
    ACT_SCRATCH_QUAD   = 4'd7,
    ACT_RESET_SCRATCH  = 4'd8
  } action_t;

  // Configuration register indexes (word address)
  localparam logic [1:0] CFG_FIRST_REG_OFFSET  = 2'd0;
  localparam logic [1:0] CFG_SCRATCH_TYPE_CODE = 2'd1;
  localparam logic [1:0] CFG_STACK_FLOAT_CODE  = 2'd2;
  localparam logic [1:0] CFG_STACK_DOUBLE_CODE = 2'd3;

  // Configuration reset values
  localparam logic [4:0] RST_FIRST_REG_OFFSET  = 5'd8;
  localparam logic [3:0] RST_SCRATCH_TYPE_CODE = 4'd7;
  localparam logic [3:0] RST_STACK_FLOAT_CODE  = 4'd3;
  localparam logic [3:0] RST_STACK_DOUBLE_CODE = 4'd4;

  // Scratch counter limits
  localparam logic [5:0] SCRATCH_MAX       = 6'd63;
  localparam logic [5:0] SCRATCH_QUAD_LIM  = 6'd4;

endpackage

@@ rtl/fpu_register_slot_allocator_top.sv @@
// Top level of the vector register slot allocator: request register, allocation
// logic, slot state, scratch counter and APB configuration registers.
// Depends on fpra_pkg.
`timescale 1ns / 1ps

// Usage
//   Requests enter on start with action, slot_type, slot_tag and free_reg; one is
//   taken at every rising edge where start is high and busy is low. busy is high
//   only during reset, so a request can be issued in every cycle.
//   Each request yields exactly one result: done pulses for one cycle with
//   reg_number, no_room and extra_taken_warning. The request passes through the
//   request register, then the result register, before its result appears.
//   Throughput is one request per cycle: the first-free search is a priority
//   encoder over the slot use bits, and the slot state updates in the same cycle
//   the result register loads, so the next request sees the new state.
//   The receiver cannot stall; results are never held.
//   Configuration is a 4-register APB port (first_reg_offset, scratch_type_code,
//   stack_float_code, stack_double_code at byte addresses 0, 4, 8, 12), written
//   while no request is in flight. pready is always high.
//   Reset clears all slots, the scratch counter and the extra quad pair, and
//   restores the configuration defaults; no clearing pass is needed.
module fpu_register_slot_allocator_top
  import fpra_pkg::*;
#(
  parameter int NUM_SLOTS = 24
) (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  action,
  input  logic [3:0]  slot_type,
  input  logic [3:0]  slot_tag,
  input  logic [5:0]  free_reg,
  // result channel
  output logic        done,
  output logic [5:0]  reg_number,
  output logic        no_room,
  output logic        extra_taken_warning,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int NP = NUM_SLOTS / 2;
  localparam logic [5:0] SLOTS6 = 6'(NUM_SLOTS);

  // Configuration registers
  logic [4:0] first_reg_offset;
  logic [3:0] scratch_type_code;
  logic [3:0] stack_float_code;
  logic [3:0] stack_double_code;

  // Request register
  logic       in_valid;
  logic [3:0] in_action;
  logic [3:0] in_type;
  logic [3:0] in_tag;
  logic [5:0] in_free_reg;

  // Slot and scratch state
  logic [NUM_SLOTS-1:0] slot_used;
  logic [3:0]           slot_kind  [NUM_SLOTS];
  logic [3:0]           slot_label [NUM_SLOTS];
  logic [5:0]           scratch_count;
  logic [5:0]           extra_quad_reg;
  logic                 extra_quad_valid;

  // Next values
  logic [NUM_SLOTS-1:0] slot_used_next;
  logic [3:0]           slot_kind_next  [NUM_SLOTS];
  logic [3:0]           slot_label_next [NUM_SLOTS];
  logic [5:0]           scratch_count_next;
  logic [5:0]           extra_quad_reg_next;
  logic                 extra_quad_valid_next;
  logic [5:0]           reg_number_next;
  logic                 no_room_next;
  logic                 warn_next;

  // Search and decode signals
  logic [NUM_SLOTS-1:0] free_bits;
  logic [NUM_SLOTS-1:0] single_mask;
  logic [SW-1:0]        single_idx;
  logic                 single_ok;
  logic [NP-1:0]        pair_free;
  logic [NP-1:0]        pair_onehot;
  logic [NUM_SLOTS-1:0] pair_mask;
  logic [SW-1:0]        pair_idx;
  logic                 pair_ok;
  logic [6:0]           fr_diff;
  logic                 fr_ok;
  logic [SW-1:0]        fr_slot;
  logic [NUM_SLOTS-1:0] fr_mask;
  logic [NUM_SLOTS-1:0] fr_pair_mask;
  logic                 fr_keep;
  logic [6:0]           ex_diff;
  logic                 ex_ok;
  logic [NUM_SLOTS-1:0] ex_mask;
  logic [NUM_SLOTS-1:0] ex_pair_mask;
  logic [NUM_SLOTS-1:0] set_mask;
  logic [3:0]           set_kind;
  logic [3:0]           set_label;
  logic [NUM_SLOTS-1:0] clr_used;
  logic [NUM_SLOTS-1:0] clr_tags;
  logic [6:0]           dbl_base;
  logic [6:0]           quad_base;
  logic [5:0]           single_reg;
  logic [5:0]           pair_reg;

  assign busy   = rst;
  assign pready = 1'b1;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      first_reg_offset  <= RST_FIRST_REG_OFFSET;
      scratch_type_code <= RST_SCRATCH_TYPE_CODE;
      stack_float_code  <= RST_STACK_FLOAT_CODE;
      stack_double_code <= RST_STACK_DOUBLE_CODE;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        CFG_FIRST_REG_OFFSET:  first_reg_offset  <= pwdata[4:0];
        CFG_SCRATCH_TYPE_CODE: scratch_type_code <= pwdata[3:0];
        CFG_STACK_FLOAT_CODE:  stack_float_code  <= pwdata[3:0];
        CFG_STACK_DOUBLE_CODE: stack_double_code <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // Configuration reads
  always_comb begin
    unique case (paddr[3:2])
      CFG_FIRST_REG_OFFSET:  prdata = {27'd0, first_reg_offset};
      CFG_SCRATCH_TYPE_CODE: prdata = {28'd0, scratch_type_code};
      CFG_STACK_FLOAT_CODE:  prdata = {28'd0, stack_float_code};
      CFG_STACK_DOUBLE_CODE: prdata = {28'd0, stack_double_code};
      default:               prdata = 32'd0;
    endcase
  end

  // Request register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_action   <= action;
      in_type     <= slot_type;
      in_tag      <= slot_tag;
      in_free_reg <= free_reg;
    end
  end

  // First free single slot: isolate the lowest set free bit
  assign free_bits   = ~slot_used;
  assign single_mask = free_bits & (~free_bits + NUM_SLOTS'(1));
  assign single_ok   = |free_bits;

  // First free even-aligned pair
  always_comb begin
    for (int p = 0; p < NP; p++) begin
      pair_free[p] = free_bits[2*p] && free_bits[2*p+1];
    end
  end
  assign pair_onehot = pair_free & (~pair_free + NP'(1));
  assign pair_ok     = |pair_free;

  always_comb begin
    pair_mask = '0;
    for (int p = 0; p < NP; p++) begin
      pair_mask[2*p]   = pair_onehot[p];
      pair_mask[2*p+1] = pair_onehot[p];
    end
  end

  // Encode the one-hot picks into slot indexes
  always_comb begin
    single_idx = '0;
    pair_idx   = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (single_mask[i]) single_idx = single_idx | SW'(i);
    end
    for (int p = 0; p < NP; p++) begin
      if (pair_onehot[p]) pair_idx = pair_idx | SW'(2*p);
    end
  end

  assign single_reg = 6'(single_idx) + 6'(first_reg_offset);
  assign pair_reg   = 6'(pair_idx) + 6'(first_reg_offset);

  // Map the freed register number to a slot
  assign fr_diff      = {1'b0, in_free_reg} - {2'b00, first_reg_offset};
  assign fr_ok        = !fr_diff[6] && (fr_diff[5:0] < SLOTS6);
  assign fr_slot      = fr_diff[SW-1:0];
  assign fr_mask      = fr_ok ? (NUM_SLOTS'(1) << fr_slot) : '0;
  assign fr_pair_mask = fr_mask | (fr_mask << 1);
  assign fr_keep      = fr_ok && ((slot_kind[fr_slot] == stack_float_code) ||
                                  (slot_kind[fr_slot] == stack_double_code));

  // Map the held extra quad register to a slot
  assign ex_diff      = {1'b0, extra_quad_reg} - {2'b00, first_reg_offset};
  assign ex_ok        = !ex_diff[6] && (ex_diff[5:0] < SLOTS6);
  assign ex_mask      = ex_ok ? (NUM_SLOTS'(1) << ex_diff[SW-1:0]) : '0;
  assign ex_pair_mask = ex_mask | (ex_mask << 1);

  // Scratch double and quad bases, rounded up to alignment
  assign dbl_base  = ({1'b0, scratch_count} + 7'd1) & ~7'd1;
  assign quad_base = ({1'b0, scratch_count} + 7'd3) & ~7'd3;

  // Decode the request into slot updates and a result
  always_comb begin
    set_mask              = '0;
    set_kind              = in_type;
    set_label             = in_tag;
    clr_used              = '0;
    clr_tags              = '0;
    scratch_count_next    = scratch_count;
    extra_quad_reg_next   = extra_quad_reg;
    extra_quad_valid_next = extra_quad_valid;
    reg_number_next       = '0;
    no_room_next          = 1'b0;
    warn_next             = 1'b0;
    if (in_valid) begin
      unique case (action_t'(in_action))
        ACT_GET_SINGLE: begin
          set_mask = single_mask;
          if (single_ok) reg_number_next = single_reg;
          else no_room_next = 1'b1;
        end
        ACT_GET_PAIR: begin
          set_mask = pair_mask;
          if (pair_ok) reg_number_next = pair_reg;
          else no_room_next = 1'b1;
        end
        ACT_FREE_SINGLE: begin
          clr_used = fr_mask;
          clr_tags = fr_keep ? '0 : fr_mask;
        end
        ACT_FREE_PAIR: begin
          clr_used = fr_pair_mask;
          clr_tags = fr_pair_mask;
        end
        ACT_CLEAR_ALL: begin
          clr_used = '1;
          clr_tags = '1;
        end
        ACT_SCRATCH_SINGLE: begin
          if (scratch_count == SCRATCH_MAX) begin
            no_room_next = 1'b1;
          end else begin
            reg_number_next    = scratch_count;
            scratch_count_next = scratch_count + 6'd1;
          end
        end
        ACT_SCRATCH_DOUBLE: begin
          if (dbl_base + 7'd2 > 7'(SCRATCH_MAX)) begin
            no_room_next = 1'b1;
          end else begin
            scratch_count_next = 6'(dbl_base + 7'd2);
            reg_number_next    = 6'(dbl_base >> 1);
          end
        end
        ACT_SCRATCH_QUAD: begin
          if (scratch_count > SCRATCH_QUAD_LIM) begin
            if (extra_quad_valid) begin
              warn_next       = 1'b1;
              reg_number_next = extra_quad_reg;
            end else if (!pair_ok) begin
              no_room_next = 1'b1;
            end else begin
              set_mask              = pair_mask;
              set_kind              = scratch_type_code;
              set_label             = 4'd0;
              extra_quad_reg_next   = pair_reg;
              extra_quad_valid_next = 1'b1;
              reg_number_next       = pair_reg;
            end
          end else begin
            scratch_count_next = 6'(quad_base + 7'd4);
            reg_number_next    = 6'(quad_base >> 1);
          end
        end
        ACT_RESET_SCRATCH: begin
          scratch_count_next = '0;
          if (extra_quad_valid) begin
            clr_used              = ex_pair_mask;
            clr_tags              = ex_pair_mask;
            extra_quad_valid_next = 1'b0;
            extra_quad_reg_next   = '0;
          end
        end
        default: ;
      endcase
    end
  end

  // Apply slot updates
  always_comb begin
    slot_used_next = (slot_used & ~clr_used) | set_mask;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      slot_kind_next[i]  = slot_kind[i];
      slot_label_next[i] = slot_label[i];
      if (set_mask[i]) begin
        slot_kind_next[i]  = set_kind;
        slot_label_next[i] = set_label;
      end else if (clr_tags[i]) begin
        slot_kind_next[i]  = 4'd0;
        slot_label_next[i] = 4'd0;
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_used        <= '0;
      scratch_count    <= '0;
      extra_quad_reg   <= '0;
      extra_quad_valid <= 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_kind[i]  <= 4'd0;
        slot_label[i] <= 4'd0;
      end
    end else begin
      slot_used        <= slot_used_next;
      scratch_count    <= scratch_count_next;
      extra_quad_reg   <= extra_quad_reg_next;
      extra_quad_valid <= extra_quad_valid_next;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_kind[i]  <= slot_kind_next[i];
        slot_label[i] <= slot_label_next[i];
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    reg_number          <= reg_number_next;
    no_room             <= no_room_next;
    extra_taken_warning <= warn_next;
  end

  // Every result comes from a request taken earlier, through the request and result registers
  a_done_follows_request: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 2))
    else $error("result without a matching request");

  // A failed request returns register zero and no warning
  a_no_room_clean: assert property (@(posedge clk) disable iff (rst)
    (done && no_room) |-> (reg_number == 6'd0 && !extra_taken_warning))
    else $error("no_room result carries data");

  // The extra quad pair is only held while the counter is past its quad limit
  a_extra_needs_count: assert property (@(posedge clk) disable iff (rst)
    extra_quad_valid |-> (scratch_count > SCRATCH_QUAD_LIM))
    else $error("extra quad pair held with low scratch counter");

endmodule
